/* rtl/core/sta_pkg.sv */
// Shared constants, codes and types of the slot table allocator.
`default_nettype none
package sta_pkg;

  localparam int MAX_SLOTS  = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET     = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FREE  = 2'd3;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;

  typedef struct packed {
    logic accept;
    logic commit;
  } sta_cmd_t;

endpackage
`default_nettype wire

/* rtl/core/sta_regs.sv */
// Configuration register file with its APB-style access port.
`default_nettype none
module sta_regs
  import sta_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [CNT_W-1:0] active_slots
);

  logic [CNT_W-1:0] active_slots_r;
  logic [CNT_W-1:0] active_slots_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == 1'b0);

  always_comb begin
    active_slots_nxt = active_slots_r;
    if (wr_en) begin
      active_slots_nxt = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slots_r <= ACTIVE_RESET;
    end else begin
      active_slots_r <= active_slots_nxt;
    end
  end

  assign prdata       = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, active_slots_r} : 32'd0;
  assign active_slots = active_slots_r;

endmodule
`default_nettype wire

/* rtl/core/sta_ctrl.sv */
// Request sequencer: accepts a beat, runs it, and holds the result handshake.
`default_nettype none
module sta_ctrl
  import sta_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output sta_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  always_comb begin
    cmd.accept    = in_tvalid & (state_r == S_IDLE);
    cmd.commit    = (state_r == S_EXEC) & (~out_valid_r | out_tready);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_EXEC)
    else $error("accepted beat did not start execution");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && out_valid_r && !out_tready |=> state_r == S_EXEC)
    else $error("result overwritten while the receiver stalls");

endmodule
`default_nettype wire

/* rtl/core/sta_dp.sv */
// Slot table datapath: valid bits, value memory, free-slot search and result register.
`default_nettype none
module sta_dp
  import sta_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sta_cmd_t              cmd,
  input  wire logic [OP_W-1:0]       in_operation,
  input  wire logic [VALUE_BITS-1:0] in_object_value,
  input  wire logic [IDX_W-1:0]      in_slot_index,
  input  wire logic [CNT_W-1:0]      active_slots,
  output logic      [STAT_W-1:0]     out_status,
  output logic      [IDX_W-1:0]      out_granted_slot,
  output logic      [VALUE_BITS-1:0] out_read_value,
  output logic      [CNT_W-1:0]      out_occupancy
);

  logic [VALUE_BITS-1:0] mem [MAX_SLOTS];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [OP_W-1:0]       op_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [IDX_W-1:0]      idx_r;

  logic [MAX_SLOTS-1:0]  slot_valid_r;
  logic [MAX_SLOTS-1:0]  slot_valid_nxt;
  logic [CNT_W-1:0]      used_count_r;
  logic [CNT_W-1:0]      used_count_nxt;

  logic [STAT_W-1:0]     status_r;
  logic [STAT_W-1:0]     status_nxt;
  logic [IDX_W-1:0]      granted_r;
  logic [IDX_W-1:0]      granted_nxt;
  logic [VALUE_BITS-1:0] read_value_r;
  logic [VALUE_BITS-1:0] read_value_nxt;

  logic [CNT_W-1:0]      size;
  logic [MAX_SLOTS-1:0]  free_mask;
  logic [IDX_W-1:0]      free_idx;
  logic                  any_free;
  logic                  in_range;
  logic                  mem_we;

  assign size     = (active_slots > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : active_slots;
  assign in_range = ({1'b0, idx_r} < size);

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_mask[i] = ~slot_valid_r[i] & (CNT_W'(i) < size);
    end
  end

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    used_count_nxt = used_count_r;
    status_nxt     = STAT_OK;
    granted_nxt    = '0;
    read_value_nxt = '0;
    mem_we         = 1'b0;
    case (op_r)
      OP_ALLOC: begin
        if (any_free) begin
          slot_valid_nxt[free_idx] = 1'b1;
          used_count_nxt           = used_count_r + CNT_W'(1);
          granted_nxt              = free_idx;
          mem_we                   = cmd.commit;
        end else begin
          status_nxt = STAT_FULL;
        end
      end
      OP_GET, OP_RELEASE: begin
        if (!in_range) begin
          status_nxt = STAT_RANGE;
        end else if (!slot_valid_r[idx_r]) begin
          status_nxt = STAT_FREE;
        end else if (op_r == OP_GET) begin
          read_value_nxt = rd_data_r;
        end else begin
          slot_valid_nxt[idx_r] = 1'b0;
          if (used_count_r != '0) begin
            used_count_nxt = used_count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_operation;
      value_r   <= in_object_value;
      idx_r     <= in_slot_index;
      rd_data_r <= mem[in_slot_index];
    end
    if (mem_we) begin
      mem[free_idx] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      used_count_r <= '0;
    end else if (cmd.commit) begin
      slot_valid_r <= slot_valid_nxt;
      used_count_r <= used_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r     <= status_nxt;
      granted_r    <= granted_nxt;
      read_value_r <= read_value_nxt;
    end
  end

  assign out_status       = status_r;
  assign out_granted_slot = granted_r;
  assign out_read_value   = read_value_r;
  assign out_occupancy    = used_count_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r == CNT_W'($countones(slot_valid_r)))
    else $error("occupancy count disagrees with valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r <= CNT_W'(MAX_SLOTS))
    else $error("occupancy count above table size");

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (op_r == OP_ALLOC) && any_free |=> slot_valid_r[$past(free_idx)])
    else $error("granted slot not marked occupied");

endmodule
`default_nettype wire

/* rtl/core/slot_table_allocator.sv */
// Top level of the slot table allocator: handle table with first-free allocation.
// Requests arrive as beats on the in_ stream: in_tuser carries the operation
// (allocate, get, release) and in_tdata the value and the slot index. Each
// request yields exactly one result beat on the out_ stream, with the status
// in out_tuser and the granted slot, read value and occupancy in out_tdata.
// A request is taken in S_IDLE and resolved in S_EXEC, where the value
// memory has been read and the free-slot priority encoder picks the lowest
// free slot below the active size; in_tready is high again the cycle after
// the commit. No new request is taken while one is in S_EXEC, which does not
// stall while the receiver keeps out_tready high. The result sits in an
// output register: the next request is accepted while it waits, and that
// request only stalls in S_EXEC until the pending result is taken.
// The APB-style port holds the active size register wherever paddr[2] is 0.
// Synchronous reset clears all valid bits, the occupancy count and the
// handshakes, and sets the active size to 16; stored values are not cleared.
`default_nettype none
module slot_table_allocator
  import sta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // object_value[31:0], slot_index[35:32], zero pad
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // granted_slot[3:0], read_value[35:4], occupancy[40:36]
  output logic      [1:0]  out_tuser,  // status[1:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  sta_cmd_t              cmd;
  logic [CNT_W-1:0]      active_slots;
  logic [STAT_W-1:0]     status;
  logic [IDX_W-1:0]      granted_slot;
  logic [VALUE_BITS-1:0] read_value;
  logic [CNT_W-1:0]      occupancy;

  sta_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .active_slots (active_slots)
  );

  sta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sta_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_tuser),
    .in_object_value  (in_tdata[31:0]),
    .in_slot_index    (in_tdata[35:32]),
    .active_slots     (active_slots),
    .out_status       (status),
    .out_granted_slot (granted_slot),
    .out_read_value   (read_value),
    .out_occupancy    (occupancy)
  );

  assign out_tuser = status;
  assign out_tdata = {7'd0, occupancy, read_value, granted_slot};

endmodule
`default_nettype wire
